// ----- design/pts_pkg.sv -----
`default_nettype none
package pts_pkg;
    localparam int MaxTasks = 16;
    localparam int IdW = 4;
    localparam int CntW = 5;
    localparam int PriW = 8;
    localparam int TmrW = 8;
    localparam int RrW = 5;

    localparam logic [2:0] REQ_TICK = 3'd0;
    localparam logic [2:0] REQ_INIT = 3'd1;
    localparam logic [2:0] REQ_LAUNCH = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_SLEEP = 3'd4;
    localparam logic [2:0] REQ_WAIT = 3'd5;
    localparam logic [2:0] REQ_WAITTMR = 3'd6;
    localparam logic [2:0] REQ_SETTMR = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BADID = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, apply simple updates
        logic tick;     // one timer per cycle at scan index
        logic sort_clr; // clear placed flags, start sorting
        logic sort_cmp; // compare entry at scan index
        logic sort_put; // write best into slot
        logic find;     // search ready entry at scan index
        logic commit;   // check round-robin candidate and commit decision
        logic scan_clr; // zero scan index
    } pts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan index at last in-use task
        logic slot_last; // slot index at last in-use task
        logic found;     // ready entry seen at scan index
        logic list_end;  // scan index at end of list
        logic resched;   // request needs scheduling
        logic launch;    // request is launch
        logic tick;      // request is tick
        logic empty;     // no tasks in use
    } pts_sts_t;
endpackage
`default_nettype wire

// ----- design/pts_ram.sv -----
`default_nettype none
module pts_ram #(
    parameter int Width = 4,
    parameter int Depth = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(Depth)-1:0]   waddr,
    input  wire [Width-1:0]           wdata,
    input  wire [$clog2(Depth)-1:0]   raddr,
    output logic [Width-1:0]          rdata
);
    logic [Width-1:0] mem [Depth];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/pts_ctrl.sv -----
`default_nettype none
module pts_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_fire,
    output logic             in_rdy,
    output logic             out_load,
    input  wire              out_free,
    output pts_pkg::pts_cmd_t cmd,
    input  wire pts_pkg::pts_sts_t sts
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC = 4'd1;
    localparam logic [3:0] S_TICK = 4'd2;
    localparam logic [3:0] S_SCMP = 4'd3;
    localparam logic [3:0] S_SPUT = 4'd4;
    localparam logic [3:0] S_FRD = 4'd5;
    localparam logic [3:0] S_FIND = 4'd6;
    localparam logic [3:0] S_RRRD = 4'd7;
    localparam logic [3:0] S_RRCK = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;
    localparam logic [3:0] S_FRD2 = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_rdy = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.tick && !sts.empty)
                begin
                    state_next = S_TICK;
                end
                else if (sts.launch)
                begin
                    cmd.sort_clr = 1'b1;
                    state_next = sts.empty ? S_FRD : S_SCMP;
                end
                else if (sts.resched)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TICK:
            begin
                cmd.tick = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_SCMP:
            begin
                cmd.sort_cmp = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SPUT;
                end
            end
            S_SPUT:
            begin
                cmd.sort_put = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next = sts.slot_last ? S_FRD : S_SCMP;
            end
            S_FRD:
            begin
                state_next = S_FRD2;
            end
            S_FRD2:
            begin
                // list read issued at index, data next
                state_next = S_FIND;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
                if (sts.list_end)
                begin
                    state_next = S_DONE;
                end
                else if (sts.found)
                begin
                    state_next = S_RRRD;
                end
                else
                begin
                    state_next = S_FRD2;
                end
            end
            S_RRRD:
            begin
                state_next = S_RRCK;
            end
            S_RRCK:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/pts_dp.sv -----
`default_nettype none
module pts_dp (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [pts_pkg::CntW-1:0]      cfg_data,
    input  wire [2:0]                    req_type,
    input  wire [pts_pkg::IdW-1:0]       task_id,
    input  wire [pts_pkg::PriW-1:0]      priority_req,
    input  wire                          initially_ready,
    input  wire [pts_pkg::TmrW-1:0]      ticks,
    input  wire pts_pkg::pts_cmd_t       cmd,
    output pts_pkg::pts_sts_t            sts,
    output logic [pts_pkg::IdW-1:0]      res_task,
    output logic [1:0]                   res_status,
    output logic                         res_resched
);
    localparam int N = pts_pkg::MaxTasks;
    localparam int IW = pts_pkg::IdW;

    logic [pts_pkg::CntW-1:0] count_reg;
    logic [pts_pkg::PriW-1:0] pri_reg [N];
    logic [N-1:0]             rdy_reg;
    logic [pts_pkg::TmrW-1:0] tmr_reg [N];
    logic [IW:0]              len_reg;
    logic [IW-1:0]            cur_reg;
    logic [pts_pkg::PriW-1:0] last_reg;
    logic [pts_pkg::RrW-1:0]  rr_reg;
    logic [2:0]               req_reg;
    logic [1:0]               status_reg;
    logic                     resched_reg;
    logic [IW:0]              idx_reg;
    logic [IW:0]              slot_reg;
    logic [N-1:0]             placed_reg;
    logic [pts_pkg::PriW-1:0] best_reg;
    logic [IW-1:0]            bidx_reg;
    logic [IW:0]              first_reg;
    logic [IW-1:0]            ftask_reg;
    logic [pts_pkg::RrW-1:0]  rrn_reg;
    logic                     rrok_reg;

    logic [IW:0]     n;
    logic            id_ok;
    logic [IW-1:0]   ram_raddr;
    logic [IW-1:0]   ram_rdata;
    logic [IW-1:0]   ix;
    logic [IW+pts_pkg::RrW:0] j;
    logic            pri_eq;

    assign n = (count_reg > pts_pkg::CntW'(N)) ? (IW+1)'(N) : (IW+1)'(count_reg);
    assign id_ok = ({1'b0, task_id} < n);
    assign ix = idx_reg[IW-1:0];
    assign j = (IW+pts_pkg::RrW+1)'(first_reg) + (IW+pts_pkg::RrW+1)'(rrn_reg);

    // candidate list read address: search walks idx, round robin reads first+offset
    assign ram_raddr = (cmd.find || !rrok_reg) ? ix : j[IW-1:0];

    pts_ram #(.Width(IW), .Depth(N)) u_list (
        .clk  (clk),
        .we   (cmd.sort_put),
        .waddr(slot_reg[IW-1:0]),
        .wdata(bidx_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign pri_eq = (pri_reg[ram_rdata] == last_reg);

    assign sts.scan_last = (idx_reg + 1'b1 >= n);
    assign sts.slot_last = (slot_reg + 1'b1 >= n);
    assign sts.found = rdy_reg[ram_rdata];
    assign sts.list_end = (idx_reg >= len_reg);
    assign sts.resched = (req_reg == pts_pkg::REQ_TICK) || (req_reg == pts_pkg::REQ_SLEEP)
        || (req_reg == pts_pkg::REQ_WAIT)
        || ((req_reg == pts_pkg::REQ_WAITTMR) && (tmr_reg[cur_reg] != '0));
    assign sts.launch = (req_reg == pts_pkg::REQ_LAUNCH);
    assign sts.tick = (req_reg == pts_pkg::REQ_TICK);
    assign sts.empty = (n == '0);

    assign res_task = cur_reg;
    assign res_status = status_reg;
    assign res_resched = resched_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= pts_pkg::CntW'(11);
            rdy_reg <= '0;
            len_reg <= '0;
            cur_reg <= '0;
            last_reg <= '0;
            rr_reg <= '0;
            req_reg <= pts_pkg::REQ_TICK;
            idx_reg <= '0;
            slot_reg <= '0;
            placed_reg <= '0;
            best_reg <= '0;
            bidx_reg <= '0;
            first_reg <= '0;
            ftask_reg <= '0;
            rrn_reg <= '0;
            status_reg <= pts_pkg::ST_OK;
            resched_reg <= 1'b0;
            rrok_reg <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                pri_reg[k] <= '0;
                tmr_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            // scan index: cleared, or stepped by tick, sort compare and search miss
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.tick || cmd.sort_cmp
                     || (cmd.find && !sts.list_end && !sts.found))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                req_reg <= req_type;
                status_reg <= pts_pkg::ST_OK;
                resched_reg <= 1'b0;
                rrok_reg <= 1'b0;
                case (req_type)
                    pts_pkg::REQ_INIT, pts_pkg::REQ_START, pts_pkg::REQ_SETTMR:
                    begin
                        if (!id_ok)
                        begin
                            status_reg <= pts_pkg::ST_BADID;
                        end
                        else if (req_type == pts_pkg::REQ_INIT)
                        begin
                            pri_reg[task_id] <= priority_req;
                            rdy_reg[task_id] <= initially_ready;
                            tmr_reg[task_id] <= '0;
                        end
                        else if (req_type == pts_pkg::REQ_START)
                        begin
                            rdy_reg[task_id] <= 1'b1;
                        end
                        else
                        begin
                            tmr_reg[task_id] <= ticks;
                        end
                    end
                    pts_pkg::REQ_SLEEP:
                    begin
                        tmr_reg[cur_reg] <= (ticks == '0) ? pts_pkg::TmrW'(1) : ticks;
                        rdy_reg[cur_reg] <= 1'b0;
                    end
                    pts_pkg::REQ_WAIT:
                    begin
                        rdy_reg[cur_reg] <= 1'b0;
                    end
                    pts_pkg::REQ_WAITTMR:
                    begin
                        if (tmr_reg[cur_reg] != '0)
                        begin
                            rdy_reg[cur_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // tick: one timer per cycle
            if (cmd.tick)
            begin
                if (tmr_reg[ix] != '0)
                begin
                    tmr_reg[ix] <= tmr_reg[ix] - 1'b1;
                    if (tmr_reg[ix] == pts_pkg::TmrW'(1))
                    begin
                        rdy_reg[ix] <= 1'b1;
                    end
                end
            end
            // selection sort, one compare a cycle
            if (cmd.sort_clr)
            begin
                placed_reg <= '0;
                slot_reg <= '0;
                best_reg <= '0;
                bidx_reg <= '0;
                rr_reg <= '0;
                len_reg <= n;
            end
            if (cmd.sort_cmp)
            begin
                if (!placed_reg[ix] && pri_reg[ix] >= best_reg)
                begin
                    best_reg <= pri_reg[ix];
                    bidx_reg <= ix;
                end
            end
            if (cmd.sort_put)
            begin
                placed_reg[bidx_reg] <= 1'b1;
                slot_reg <= slot_reg + 1'b1;
                best_reg <= '0;
                bidx_reg <= '0;
            end
            // first ready search
            if (cmd.find)
            begin
                if (!sts.list_end)
                begin
                    if (sts.found)
                    begin
                        first_reg <= idx_reg;
                        ftask_reg <= ram_rdata;
                        rrok_reg <= 1'b1;
                        if (!sts.launch && pri_eq)
                        begin
                            rrn_reg <= rr_reg + 1'b1;
                        end
                        else
                        begin
                            rrn_reg <= '0;
                        end
                    end
                end
                else
                begin
                    resched_reg <= 1'b1;
                    status_reg <= pts_pkg::ST_NONE;
                end
            end
            // round robin check and commit
            if (cmd.commit)
            begin
                resched_reg <= 1'b1;
                if (rrn_reg != '0 && j < (IW+pts_pkg::RrW+1)'(len_reg) && pri_eq
                    && rdy_reg[ram_rdata])
                begin
                    rr_reg <= rrn_reg;
                    cur_reg <= ram_rdata;
                    last_reg <= pri_reg[ram_rdata];
                end
                else
                begin
                    rr_reg <= '0;
                    cur_reg <= ftask_reg;
                    last_reg <= pri_reg[ftask_reg];
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/priority_task_scheduler.sv -----
// channel | dir | beat contents
// s_axis  | in  | tdata: req_type, task_id, priority_req, initially_ready, ticks
// m_axis  | out | tdata: running_task, status, rescheduled
// cfg     | in  | cfg_data: task_count
// one item at a time: a request is accepted only in idle, after the last result
// went to the output register; a search reads the list entry by entry (states
// FRD2 then FIND per entry), a tick updates one timer a cycle, and launch first
// sorts with one compare a cycle
// reset clears all task state and sets task_count to 11
// an output register holds the result; a stalled m_axis holds the block
`default_nettype none
module priority_task_scheduler (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [4:0]  cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [23:0] s_axis_tdata,  // req_type, task_id, priority_req, initially_ready, ticks
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata   // running_task, status, rescheduled, zero pad
);
    pts_pkg::pts_cmd_t cmd;
    pts_pkg::pts_sts_t sts;
    logic       in_rdy, out_load;
    logic [3:0] res_task;
    logic [1:0] res_status;
    logic       res_resched;
    logic       ovalid_reg;
    logic [6:0] odata_reg;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = in_rdy;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {1'b0, odata_reg};

    pts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && in_rdy), .in_rdy(in_rdy),
        .out_load(out_load), .out_free(!ovalid_reg || m_axis_tready),
        .cmd(cmd), .sts(sts)
    );

    pts_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_valid), .cfg_data(cfg_data),
        .req_type(s_axis_tdata[2:0]), .task_id(s_axis_tdata[6:3]),
        .priority_req(s_axis_tdata[14:7]), .initially_ready(s_axis_tdata[15]),
        .ticks(s_axis_tdata[23:16]),
        .cmd(cmd), .sts(sts),
        .res_task(res_task), .res_status(res_status), .res_resched(res_resched)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            odata_reg <= {res_resched, res_status, res_task};
        end
    end
endmodule
`default_nettype wire

// ----- design/pts_checker.sv -----
`default_nettype none
module pts_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       s_axis_tvalid,
    input wire       s_axis_tready,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata
);
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // status code never three
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:4] != 2'd3)
        else $error("bad status");
    // not ready straight after accepting a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted back to back");
    // no-task status always rescheduled
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:4] == 2'd2 |-> m_axis_tdata[6])
        else $error("no-task without reschedule");
endmodule

bind priority_task_scheduler pts_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- dv/tb_priority_task_scheduler.sv -----
`default_nettype none
module tb_priority_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // req_type, task_id, priority_req, initially_ready, ticks
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // running_task, status, rescheduled, zero pad

    // result fields, lowest bits last
    typedef struct packed {
        logic       resched;
        logic [1:0] status;
        logic [3:0] task_id;
    } sched_res_t;

    // one row of the directed table
    typedef struct {
        logic [23:0] beat;
        bit          known;
        sched_res_t  want;
    } dir_row_t;

    // scheduler shadow state
    logic [7:0] sh_pri [pts_pkg::MaxTasks];
    logic       sh_rdy [pts_pkg::MaxTasks];
    logic [7:0] sh_tmr [pts_pkg::MaxTasks];
    logic [3:0] sh_order [pts_pkg::MaxTasks];
    int         sh_order_len;
    int         sh_cur;
    logic [7:0] sh_last_pri;
    logic [4:0] sh_rr;
    logic [4:0] sh_task_count;

    sched_res_t decisions_q[$];
    dir_row_t   dir_rows[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;
    bit  sink_hold = 1'b0;

    priority_task_scheduler u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic int live_count();
        return (sh_task_count < pts_pkg::MaxTasks) ? int'(sh_task_count) : pts_pkg::MaxTasks;
    endfunction

    // pick a task from the sorted list, optional round-robin step
    function automatic bit pick_task(bit use_rr);
        int first;
        int pick;
        int j;
        logic [7:0] top;
        first = sh_order_len;
        for (int i = 0; i < sh_order_len; i++)
        begin
            if (sh_rdy[sh_order[i]])
            begin
                first = i;
                break;
            end
        end
        if (first >= sh_order_len)
            return 1'b0;
        pick = first;
        top = sh_pri[sh_order[first]];
        if (use_rr && top == sh_last_pri)
        begin
            sh_rr = sh_rr + 5'd1;
            j = first + int'(sh_rr);
            if (sh_rr != 0 && j < sh_order_len && sh_pri[sh_order[j]] == top
                && sh_rdy[sh_order[j]])
                pick = j;
            else
                sh_rr = '0;
        end
        else
            sh_rr = '0;
        sh_last_pri = sh_pri[sh_order[pick]];
        sh_cur = sh_order[pick];
        return 1'b1;
    endfunction

    // sort in-use tasks by descending priority, higher id first on ties
    function automatic void sort_tasks();
        bit placed [pts_pkg::MaxTasks];
        int n;
        int best;
        int idx;
        n = live_count();
        foreach (placed[k]) placed[k] = 1'b0;
        for (int slot = 0; slot < n; slot++)
        begin
            best = 0;
            idx = 0;
            for (int k = 0; k < n; k++)
            begin
                if (!placed[k] && int'(sh_pri[k]) >= best)
                begin
                    best = int'(sh_pri[k]);
                    idx = k;
                end
            end
            placed[idx] = 1'b1;
            sh_order[slot] = idx[3:0];
        end
        sh_order_len = n;
    endfunction

    function automatic sched_res_t predict_decision(logic [23:0] beat);
        logic [2:0] req;
        logic [3:0] id;
        logic [7:0] pri;
        logic       rdy;
        logic [7:0] tk;
        bit         id_ok;
        bit         cur_ok;
        sched_res_t r;
        req = beat[2:0];
        id = beat[6:3];
        pri = beat[14:7];
        rdy = beat[15];
        tk = beat[23:16];
        id_ok = int'(id) < live_count();
        cur_ok = sh_cur < pts_pkg::MaxTasks;
        r.status = pts_pkg::ST_OK;
        r.resched = 1'b0;
        r.task_id = '0;
        case (req)
            pts_pkg::REQ_TICK:
            begin
                for (int k = 0; k < live_count(); k++)
                begin
                    if (sh_tmr[k] != 0)
                    begin
                        sh_tmr[k]--;
                        if (sh_tmr[k] == 0) sh_rdy[k] = 1'b1;
                    end
                end
                r.resched = 1'b1;
            end
            pts_pkg::REQ_INIT:
            begin
                if (!id_ok) r.status = pts_pkg::ST_BADID;
                else
                begin
                    sh_pri[id] = pri;
                    sh_rdy[id] = rdy;
                    sh_tmr[id] = '0;
                end
            end
            pts_pkg::REQ_LAUNCH:
            begin
                sort_tasks();
                sh_rr = '0;
                if (!pick_task(1'b0)) r.status = pts_pkg::ST_NONE;
                r.task_id = sh_cur[3:0];
                r.resched = 1'b1;
                return r;
            end
            pts_pkg::REQ_START:
            begin
                if (!id_ok) r.status = pts_pkg::ST_BADID;
                else sh_rdy[id] = 1'b1;
            end
            pts_pkg::REQ_SLEEP:
            begin
                if (tk == 0) tk = 8'd1;
                if (cur_ok)
                begin
                    sh_tmr[sh_cur] = tk;
                    sh_rdy[sh_cur] = 1'b0;
                end
                r.resched = 1'b1;
            end
            pts_pkg::REQ_WAIT:
            begin
                if (cur_ok) sh_rdy[sh_cur] = 1'b0;
                r.resched = 1'b1;
            end
            pts_pkg::REQ_WAITTMR:
            begin
                if (cur_ok && sh_tmr[sh_cur] != 0)
                begin
                    sh_rdy[sh_cur] = 1'b0;
                    r.resched = 1'b1;
                end
            end
            default:
            begin
                if (!id_ok) r.status = pts_pkg::ST_BADID;
                else sh_tmr[id] = tk;
            end
        endcase
        if (r.resched && !pick_task(1'b1)) r.status = pts_pkg::ST_NONE;
        r.task_id = sh_cur[3:0];
        return r;
    endfunction

    function automatic logic [23:0] make_beat(logic [2:0] req, logic [3:0] id,
                                              logic [7:0] pri, logic rdy,
                                              logic [7:0] tk);
        return {tk, rdy, pri, id, req};
    endfunction

    function automatic void add_row(logic [23:0] beat, bit known, sched_res_t want);
        dir_row_t row;
        row.beat = beat;
        row.known = known;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // one request beat, with a random gap before it
    task automatic send_req(logic [23:0] beat);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        s_axis_tdata <= beat;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        decisions_q.push_back(predict_decision(beat));
        n_sent++;
    endtask

    // directed beat with a result typed in by hand
    task automatic send_known(logic [23:0] beat, sched_res_t want);
        sched_res_t got;
        send_req(beat);
        got = decisions_q[$];
        if (got !== want)
        begin
            $display("%0t directed prediction: expected %h actual %h", $time, want, got);
            errors++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decisions_q.size() != 0) @(posedge clk);
        wait_cycles(300);
    endtask

    task automatic write_task_count(logic [4:0] val);
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sh_task_count = val;
    endtask

    // well-formed kernel session: init, launch, then a mix of calls
    task automatic run_session(int n_calls);
        int n;
        n = live_count();
        for (int k = 0; k < n; k++)
            send_req(make_beat(pts_pkg::REQ_INIT, k[3:0], ($urandom_range(0, 3) == 0) ?
                     8'($urandom) : 8'($urandom_range(0, 3)),
                     1'($urandom), 8'($urandom)));
        send_req(make_beat(pts_pkg::REQ_LAUNCH, 4'($urandom), 8'($urandom), 1'($urandom),
                 8'($urandom)));
        for (int c = 0; c < n_calls; c++)
        begin
            logic [2:0] req;
            logic [7:0] tk;
            req = 3'($urandom);
            tk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            send_req(make_beat(req, 4'($urandom_range(0, n)), 8'($urandom),
                     1'($urandom), tk));
        end
    endtask

    // result checker
    initial
    begin
        sched_res_t got;
        sched_res_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[6:0];
                if (decisions_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = decisions_q.pop_front();
                    if (got.task_id !== want.task_id)
                    begin
                        $display("%0t running_task: expected %0d actual %0d", $time,
                                 want.task_id, got.task_id);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t status: expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                    if (got.resched !== want.resched)
                    begin
                        $display("%0t rescheduled: expected %0d actual %0d", $time,
                                 want.resched, got.resched);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random wait before each beat, held off while sink_hold
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                wait_cycles(gap);
            end
            while (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (n_sent >= 300);
        sink_hold = 1'b1;
        wait_cycles(400);
        sink_hold = 1'b0;
    end

    // watchdog on beats
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        sched_res_t none_res;
        sched_res_t bad_res;
        sched_res_t no_res;
        logic [4:0] counts [6];
        foreach (sh_pri[k])
        begin
            sh_pri[k] = '0;
            sh_rdy[k] = 1'b0;
            sh_tmr[k] = '0;
            sh_order[k] = '0;
        end
        sh_order_len = 0;
        sh_cur = 0;
        sh_last_pri = '0;
        sh_rr = '0;
        sh_task_count = 5'd11;
        wait_cycles(7);
        rst_n <= 1'b1;
        wait_cycles(2);

        // directed table: scheduling before launch, rejected ids, extremes
        none_res = '{resched: 1'b1, status: pts_pkg::ST_NONE, task_id: 4'd0};
        bad_res = '{resched: 1'b0, status: pts_pkg::ST_BADID, task_id: 4'd0};
        no_res = '0;
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b1, none_res);
        add_row(make_beat(pts_pkg::REQ_WAIT, 4'd0, 8'd0, 1'b0, 8'd0), 1'b1, none_res);
        add_row(make_beat(pts_pkg::REQ_INIT, 4'd15, 8'hff, 1'b1, 8'hff), 1'b1, bad_res);
        add_row(make_beat(pts_pkg::REQ_START, 4'd11, 8'd0, 1'b0, 8'd0), 1'b1, bad_res);
        add_row(make_beat(pts_pkg::REQ_SETTMR, 4'd12, 8'd0, 1'b0, 8'd9), 1'b1, bad_res);
        add_row(make_beat(pts_pkg::REQ_LAUNCH, 4'd0, 8'd0, 1'b0, 8'd0), 1'b1, none_res);
        add_row(make_beat(pts_pkg::REQ_INIT, 4'd0, 8'hff, 1'b1, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_INIT, 4'd10, 8'hff, 1'b1, 8'hff), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_INIT, 4'd3, 8'hff, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_INIT, 4'd5, 8'd0, 1'b1, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_START, 4'd3, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_LAUNCH, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        // equal priorities: round robin and offset past list
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        // sleep of zero, timer waits, set timer to extremes
        add_row(make_beat(pts_pkg::REQ_SLEEP, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_WAITTMR, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_SETTMR, 4'd10, 8'd0, 1'b0, 8'hff), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_WAITTMR, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_SLEEP, 4'd0, 8'd0, 1'b0, 8'd2), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_WAIT, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        add_row(make_beat(pts_pkg::REQ_TICK, 4'd0, 8'd0, 1'b0, 8'd0), 1'b0, no_res);
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].known)
                send_known(dir_rows[r].beat, dir_rows[r].want);
            else
                send_req(dir_rows[r].beat);
        end
        drain();

        // random sessions over several task counts, extremes included
        counts = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd0, 5'd7};
        for (int p = 0; p < 6; p++)
        begin
            write_task_count(counts[p]);
            for (int s = 0; s < 4; s++)
            begin
                if ($urandom_range(0, 7) == 0)
                    for (int z = 0; z < 8; z++)
                        send_req(24'($urandom));
                else
                    run_session($urandom_range(55, 85));
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
design/pts_pkg.sv
design/pts_ram.sv
design/pts_ctrl.sv
design/pts_dp.sv
design/priority_task_scheduler.sv
design/pts_checker.sv
dv/tb_priority_task_scheduler.sv
